/* rtl/pts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the priority task scheduler.
// No dependencies.
package pts_pkg;

  localparam int FUNC_W     = 2;
  localparam int DLY_W      = 16;
  localparam int MASK_W     = 8;
  localparam int TASK_W     = 3;
  localparam int INTERVAL_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [INTERVAL_W-1:0] SWITCH_INTERVAL_RST = 10'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_TASK_PRESENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_ENABLED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_INTERVAL = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK  = 2'd0,
    FN_DELAY = 2'd1,
    FN_WAIT  = 2'd2,
    FN_START = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_INIT      = 2'd0,
    ST_READY     = 2'd1,
    ST_RUNNING   = 2'd2,
    ST_SUSPENDED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TICKEND,
    S_SEL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [DLY_W-1:0] start;
    logic [DLY_W-1:0] length;
  } dly_entry_t;

endpackage

/* rtl/pts_in_if.sv */
`timescale 1ns / 1ps
// Request channel of the scheduler: valid/ready plus one request word.
// Depends on pts_pkg.
interface pts_in_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DLY_W-1:0]  delay_ticks;
  logic [MASK_W-1:0] event_pending;

  modport source (output valid, func, delay_ticks, event_pending, input ready);
  modport sink   (input valid, func, delay_ticks, event_pending, output ready);
endinterface

/* rtl/pts_out_if.sv */
`timescale 1ns / 1ps
// Result channel of the scheduler: valid/ready plus one result word.
// Depends on pts_pkg.
interface pts_out_if import pts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              switch_request;
  logic              current_valid;
  logic [TASK_W-1:0] current_task;
  logic [MASK_W-1:0] runnable_mask;

  modport source (output valid, switch_request, current_valid, current_task,
                  runnable_mask, input ready);
  modport sink   (input valid, switch_request, current_valid, current_task,
                  runnable_mask, output ready);
endinterface

/* rtl/pts_delay_unit.sv */
`timescale 1ns / 1ps
// Per-task delay table (start tick, length) in a one-port synchronous RAM,
// with the expiry compare on the registered read word. Depends on pts_pkg.
module pts_delay_unit import pts_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic                         re,
  input  logic [$clog2(NUM_TASKS)-1:0] addr,
  input  dly_entry_t                   wdata,
  input  logic [DLY_W-1:0]             tick_count,
  output logic                         expired
);

  dly_entry_t       mem_r [NUM_TASKS];
  dly_entry_t       rd_r;
  logic [DLY_W-1:0] gone;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rd_r <= mem_r[addr];
    end
  end

  // modular distance since the delay began
  assign gone    = DLY_W'(tick_count - rd_r.start);
  assign expired = (gone >= rd_r.length);

endmodule

/* rtl/priority_task_scheduler_top.sv */
`timescale 1ns / 1ps
// Fixed-priority task scheduler, lower slot index wins.
// Channels: in_ch takes one request word (tick, delay, wait, start) per
// valid/ready handshake; out_ch returns exactly one result word per request
// (switch request, current task, runnable mask). cfg_we/cfg_idx/cfg_wdata
// write task_present (0), event_enabled (1) and switch_interval (2); the user
// must make writes only while no request is in flight (the block does not enforce it).
// Start passes select and done; delay and wait pass exec, select if the
// task suspends, and done; tick passes scan, tick end, select if a switch
// is due, and done. A tick walks the delay RAM one slot per cycle through
// its single port, which sets the tick time; one request is worked on at a time.
// The result sits in an output register, so a new request is taken while the
// previous result still waits for out_ch.ready; a stalled receiver holds the
// block only when a second result is ready to be written.
// Reset (rst_n low, synchronous) clears all tasks to init, no delays, tick
// and interval counts to zero, switch_interval to 10, no current task.
// The delay RAM needs no clearing: per-slot active flags mark live entries.
// Depends on pts_pkg, pts_in_if, pts_out_if and pts_delay_unit.
module priority_task_scheduler_top import pts_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pts_in_if.sink                in_ch,
  pts_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
  localparam logic [IDX_W:0]   CNT_END  = (IDX_W + 1)'(NUM_TASKS);

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;
  logic [DLY_W-1:0]      dly_r, dly_nxt;
  logic [MASK_W-1:0]     ev_r, ev_nxt;
  logic [MASK_W-1:0]     present_r, present_nxt;
  logic [MASK_W-1:0]     evt_en_r, evt_en_nxt;
  logic [INTERVAL_W-1:0] swi_r, swi_nxt;
  status_t               status_r [NUM_TASKS];
  status_t               status_nxt [NUM_TASKS];
  logic [NUM_TASKS-1:0]  active_r, active_nxt;
  logic [DLY_W-1:0]      tick_r, tick_nxt;
  logic [INTERVAL_W-1:0] icnt_r, icnt_nxt;
  logic [IDX_W-1:0]      ri_r, ri_nxt;
  logic                  rv_r, rv_nxt;
  logic                  sw_r, sw_nxt;
  logic [IDX_W:0]        scan_cnt_r, scan_cnt_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_sw_r, out_sw_nxt;
  logic                  out_cv_r, out_cv_nxt;
  logic [TASK_W-1:0]     out_task_r, out_task_nxt;
  logic [MASK_W-1:0]     out_mask_r, out_mask_nxt;

  logic [NUM_TASKS-1:0]  present_v, evt_v, ev_v, newp_v, runnable;
  logic                  in_acc, out_free, have, dly_ok, wait_ok;
  logic                  scan_issue, scan_last, found;
  logic [IDX_W-1:0]      sel_idx, dm_addr;
  logic [INTERVAL_W-1:0] ic_inc;
  logic                  ic_hit;
  logic                  dm_we, dm_re, expired;
  dly_entry_t            dm_wdata;

  // Slot vectors; slots beyond the 8-bit registers are never present.
  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_slot
    if (g < MASK_W) begin : g_map
      assign present_v[g] = present_r[g];
      assign evt_v[g]     = evt_en_r[g];
      assign ev_v[g]      = ev_r[g];
      assign newp_v[g]    = cfg_wdata[g];
    end else begin : g_none
      assign present_v[g] = 1'b0;
      assign evt_v[g]     = 1'b0;
      assign ev_v[g]      = 1'b0;
      assign newp_v[g]    = 1'b0;
    end
    assign runnable[g] = present_v[g] &&
                         (status_r[g] == ST_READY || status_r[g] == ST_RUNNING);
  end

  always_comb begin
    found   = |runnable;
    sel_idx = '0;
    for (int i = NUM_TASKS - 1; i >= 0; i--) begin
      if (runnable[i]) begin
        sel_idx = IDX_W'(i);
      end
    end
  end

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign have       = rv_r && present_v[ri_r];
  assign dly_ok     = have && (dly_r != '0) && !active_r[ri_r];
  assign wait_ok    = have && evt_v[ri_r] && !ev_v[ri_r];
  assign scan_issue = (state_r == S_SCAN) && (scan_cnt_r < CNT_END);
  assign scan_last  = chk_vld_r && (chk_idx_r == LAST_IDX);
  assign ic_inc     = INTERVAL_W'(icnt_r + 1'b1);
  assign ic_hit     = (ic_inc >= swi_r);

  assign dm_addr  = (state_r == S_EXEC) ? ri_r : scan_cnt_r[IDX_W-1:0];
  assign dm_wdata = '{start: tick_r, length: dly_r};

  pts_delay_unit #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dly (
    .clk        (clk),
    .we         (dm_we),
    .re         (dm_re),
    .addr       (dm_addr),
    .wdata      (dm_wdata),
    .tick_count (tick_r),
    .expired    (expired)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (func_t'(in_ch.func))
            FN_TICK:  state_nxt = S_SCAN;
            FN_START: state_nxt = S_SEL;
            default:  state_nxt = S_EXEC;
          endcase
        end
      end
      S_EXEC: begin
        if ((func_r == FN_DELAY && dly_ok) || (func_r == FN_WAIT && wait_ok)) begin
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_TICKEND;
        end
      end
      S_TICKEND: state_nxt = (sw_r || ic_hit) ? S_SEL : S_DONE;
      S_SEL:     state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    func_nxt     = func_r;
    dly_nxt      = dly_r;
    ev_nxt       = ev_r;
    present_nxt  = present_r;
    evt_en_nxt   = evt_en_r;
    swi_nxt      = swi_r;
    status_nxt   = status_r;
    active_nxt   = active_r;
    tick_nxt     = tick_r;
    icnt_nxt     = icnt_r;
    ri_nxt       = ri_r;
    rv_nxt       = rv_r;
    sw_nxt       = sw_r;
    scan_cnt_nxt = scan_cnt_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    out_sw_nxt   = out_sw_r;
    out_cv_nxt   = out_cv_r;
    out_task_nxt = out_task_r;
    out_mask_nxt = out_mask_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    dm_we        = 1'b0;
    dm_re        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt     = func_t'(in_ch.func);
          dly_nxt      = in_ch.delay_ticks;
          ev_nxt       = in_ch.event_pending;
          sw_nxt       = 1'b0;
          scan_cnt_nxt = '0;
        end
      end
      S_EXEC: begin
        if (func_r == FN_DELAY && dly_ok) begin
          dm_we              = 1'b1;
          active_nxt[ri_r]   = 1'b1;
          status_nxt[ri_r]   = ST_SUSPENDED;
          sw_nxt             = 1'b1;
        end else if (func_r == FN_WAIT && wait_ok) begin
          status_nxt[ri_r]   = ST_SUSPENDED;
          sw_nxt             = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_issue) begin
          dm_re        = 1'b1;
          scan_cnt_nxt = (IDX_W + 1)'(scan_cnt_r + 1'b1);
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = scan_cnt_r[IDX_W-1:0];
        end
        // RAM word of chk_idx_r is on the read register this cycle
        if (chk_vld_r && present_v[chk_idx_r]) begin
          if (active_r[chk_idx_r]) begin
            if (expired) begin
              active_nxt[chk_idx_r] = 1'b0;
              status_nxt[chk_idx_r] = ST_READY;
              sw_nxt                = 1'b1;
            end else begin
              status_nxt[chk_idx_r] = ST_SUSPENDED;
            end
          end
          // event state overrides the delay outcome
          if (evt_v[chk_idx_r]) begin
            if (ev_v[chk_idx_r]) begin
              status_nxt[chk_idx_r] = ST_READY;
              sw_nxt                = 1'b1;
            end else begin
              status_nxt[chk_idx_r] = ST_SUSPENDED;
            end
          end
        end
      end
      S_TICKEND: begin
        tick_nxt = DLY_W'(tick_r + 1'b1);
        if (ic_hit) begin
          icnt_nxt = '0;
          sw_nxt   = 1'b1;
        end else begin
          icnt_nxt = ic_inc;
        end
      end
      S_SEL: begin
        if (found) begin
          status_nxt[sel_idx] = ST_RUNNING;
          ri_nxt              = sel_idx;
          rv_nxt              = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sw_nxt    = sw_r;
          out_cv_nxt    = rv_r;
          out_task_nxt  = TASK_W'(ri_r);
          out_mask_nxt  = MASK_W'(runnable);
        end
      end
      default: ;
    endcase

    if (cfg_we) begin
      case (cfg_idx)
        CFG_TASK_PRESENT: begin
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (present_v[i] != newp_v[i]) begin
              status_nxt[i] = newp_v[i] ? ST_READY : ST_INIT;
              active_nxt[i] = 1'b0;
              if (!newp_v[i] && rv_r && ri_r == IDX_W'(i)) begin
                rv_nxt = 1'b0;
              end
            end
          end
          present_nxt = cfg_wdata[MASK_W-1:0];
        end
        CFG_EVENT_ENABLED:   evt_en_nxt = cfg_wdata[MASK_W-1:0];
        CFG_SWITCH_INTERVAL: swi_nxt    = cfg_wdata[INTERVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= '0;
      evt_en_r    <= '0;
      swi_r       <= SWITCH_INTERVAL_RST;
      active_r    <= '0;
      tick_r      <= '0;
      icnt_r      <= '0;
      ri_r        <= '0;
      rv_r        <= 1'b0;
      sw_r        <= 1'b0;
      scan_cnt_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        status_r[i] <= ST_INIT;
      end
    end else begin
      state_r     <= state_nxt;
      present_r   <= present_nxt;
      evt_en_r    <= evt_en_nxt;
      swi_r       <= swi_nxt;
      active_r    <= active_nxt;
      tick_r      <= tick_nxt;
      icnt_r      <= icnt_nxt;
      ri_r        <= ri_nxt;
      rv_r        <= rv_nxt;
      sw_r        <= sw_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    dly_r      <= dly_nxt;
    ev_r       <= ev_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_sw_r   <= out_sw_nxt;
    out_cv_r   <= out_cv_nxt;
    out_task_r <= out_task_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.switch_request = out_sw_r;
  assign out_ch.current_valid  = out_cv_r;
  assign out_ch.current_task   = out_task_r;
  assign out_ch.runnable_mask  = out_mask_r;

endmodule

/* rtl/pts_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the scheduler, bound to priority_task_scheduler_top.
// Depends on pts_pkg.
module pts_checker import pts_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic                  out_sw,
  input logic                  out_cv,
  input logic [TASK_W-1:0]     out_task,
  input logic [MASK_W-1:0]     out_mask,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_idx,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [1:0]        pend_r, pend_nxt;
  logic [MASK_W-1:0] present_r, present_nxt;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt    = 2'(pend_r + {1'b0, in_acc} - {1'b0, out_acc});
    present_nxt = (cfg_we && cfg_idx == CFG_TASK_PRESENT) ?
                  cfg_wdata[MASK_W-1:0] : present_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      present_r <= '0;
    end else begin
      pend_r    <= pend_nxt;
      present_r <= present_nxt;
    end
  end

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_sw, out_cv, out_task, out_mask}))
    else $error("result word changed under stall");

  // every result word belongs to an accepted request
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 2'd0)
    else $error("result word without request");

  // at most one request in work plus one result waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("request taken with two words outstanding");

  // only present slots can be runnable
  a_mask_present: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mask & ~present_r) == '0)
    else $error("runnable mask names an empty slot");

endmodule

bind priority_task_scheduler_top pts_checker u_pts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sw    (out_ch.switch_request),
  .out_cv    (out_ch.current_valid),
  .out_task  (out_ch.current_task),
  .out_mask  (out_ch.runnable_mask),
  .cfg_we    (cfg_we),
  .cfg_idx   (cfg_idx),
  .cfg_wdata (cfg_wdata)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for priority_task_scheduler_top: scheduler model,
// request driver, result checker. Needs pts_pkg, pts_in_if, pts_out_if, RTL.
module tb;
  import pts_pkg::*;

  localparam int NUM_TASKS    = 8;
  localparam int SETTLE_CYC   = 20;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic              sw_req;
    logic              cur_vld;
    logic [TASK_W-1:0] cur_task;
    logic [MASK_W-1:0] run_mask;
  } sched_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  req_valid = 1'b0;
  func_t                 req_func = FN_TICK;
  logic [DLY_W-1:0]      req_dly = '0;
  logic [MASK_W-1:0]     req_evp = '0;
  logic                  rx_ready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = CFG_TASK_PRESENT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  assign in_ch.valid         = req_valid;
  assign in_ch.func          = req_func;
  assign in_ch.delay_ticks   = req_dly;
  assign in_ch.event_pending = req_evp;
  assign out_ch.ready        = rx_ready;

  priority_task_scheduler_top #(.NUM_TASKS(NUM_TASKS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // scheduler model state
  status_t           task_st  [NUM_TASKS];
  logic [DLY_W-1:0]  dly_from [NUM_TASKS];
  logic [DLY_W-1:0]  dly_len  [NUM_TASKS];
  logic [DLY_W-1:0]  tick_cnt;
  logic [INTERVAL_W-1:0] slice_cnt;
  logic [TASK_W-1:0] run_idx;
  logic              run_vld;
  logic [MASK_W-1:0] present_r;
  logic [MASK_W-1:0] evt_en_r;
  logic [INTERVAL_W-1:0] slice_len;

  sched_word_t sched_expect_q [$];

  int  mismatches = 0;
  int  cycle_cnt = 0;
  int  rx_gap = 0;
  bit  tx_idle = 1'b1;
  bit  rx_idle = 1'b1;
  logic hold_go = 1'b0;
  int  hold_left = 0;

  function automatic void model_reset();
    for (int i = 0; i < NUM_TASKS; i++) begin
      task_st[i]  = ST_INIT;
      dly_from[i] = '0;
      dly_len[i]  = '0;
    end
    tick_cnt  = '0;
    slice_cnt = '0;
    run_idx   = '0;
    run_vld   = 1'b0;
    present_r = '0;
    evt_en_r  = '0;
    slice_len = SWITCH_INTERVAL_RST;
  endfunction

  function automatic bit is_runnable(int i);
    return present_r[i] && (task_st[i] == ST_READY || task_st[i] == ST_RUNNING);
  endfunction

  // lowest runnable slot wins; previous runner keeps its status
  function automatic void pick_task();
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (is_runnable(i)) begin
        task_st[i] = ST_RUNNING;
        run_idx    = TASK_W'(i);
        run_vld    = 1'b1;
        return;
      end
    end
  endfunction

  function automatic void model_config(logic [CFG_IDX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    logic [MASK_W-1:0] nv;
    nv = val[MASK_W-1:0];
    case (idx)
      CFG_TASK_PRESENT: begin
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (present_r[i] != nv[i]) begin
            task_st[i]  = nv[i] ? ST_READY : ST_INIT;
            dly_from[i] = '0;
            dly_len[i]  = '0;
            if (!nv[i] && run_vld && run_idx == TASK_W'(i))
              run_vld = 1'b0;
          end
        end
        present_r = nv;
      end
      CFG_EVENT_ENABLED:   evt_en_r  = nv;
      CFG_SWITCH_INTERVAL: slice_len = val[INTERVAL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit model_tick(logic [MASK_W-1:0] evp);
    bit wake;
    logic [DLY_W-1:0] elapsed;
    wake = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (present_r[i] && dly_len[i] != '0) begin
        elapsed = tick_cnt - dly_from[i];
        if (elapsed >= dly_len[i]) begin
          dly_from[i] = '0;
          dly_len[i]  = '0;
          task_st[i]  = ST_READY;
          wake        = 1'b1;
        end else begin
          task_st[i] = ST_SUSPENDED;
        end
      end
    end
    // event sampling overrides the delay outcome
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (present_r[i] && evt_en_r[i]) begin
        if (evp[i]) begin
          task_st[i] = ST_READY;
          wake       = 1'b1;
        end else begin
          task_st[i] = ST_SUSPENDED;
        end
      end
    end
    tick_cnt  = tick_cnt + 1'b1;
    slice_cnt = slice_cnt + 1'b1;
    if (slice_cnt >= slice_len) begin
      slice_cnt = '0;
      wake      = 1'b1;
    end
    return wake;
  endfunction

  function automatic void predict_step(func_t fn, logic [DLY_W-1:0] dly,
                                       logic [MASK_W-1:0] evp);
    sched_word_t w;
    bit sw;
    bit have;
    sw   = 1'b0;
    have = run_vld && present_r[run_idx];
    case (fn)
      FN_TICK: sw = model_tick(evp);
      FN_DELAY: begin
        if (have && dly != '0 && dly_len[run_idx] == '0) begin
          dly_len[run_idx]  = dly;
          dly_from[run_idx] = tick_cnt;
          task_st[run_idx]  = ST_SUSPENDED;
          sw = 1'b1;
        end
      end
      FN_WAIT: begin
        if (have && evt_en_r[run_idx] && !evp[run_idx]) begin
          task_st[run_idx] = ST_SUSPENDED;
          sw = 1'b1;
        end
      end
      default: pick_task();
    endcase
    if (sw)
      pick_task();
    w.sw_req   = sw;
    w.cur_vld  = run_vld;
    w.cur_task = run_idx;
    for (int i = 0; i < NUM_TASKS; i++)
      w.run_mask[i] = is_runnable(i);
    sched_expect_q.push_back(w);
  endfunction

  function automatic void check_field(string name, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
               $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side: check each accepted word, then draw the next stall
  always @(posedge clk) begin : result_check
    sched_word_t want;
    if (rst_n && out_ch.valid && rx_ready) begin
      if (sched_expect_q.size() == 0) begin
        $display("%0t: unexpected word sw=%0b vld=%0b task=%0d mask=0x%0h", $time,
                 out_ch.switch_request, out_ch.current_valid,
                 out_ch.current_task, out_ch.runnable_mask);
        mismatches++;
      end else begin
        want = sched_expect_q.pop_front();
        check_field("switch_request", want.sw_req, out_ch.switch_request);
        check_field("current_valid", want.cur_vld, out_ch.current_valid);
        check_field("current_task", want.cur_task, out_ch.current_task);
        check_field("runnable_mask", want.run_mask, out_ch.runnable_mask);
      end
      rx_gap = rx_idle ? $urandom_range(0, 7) : 0;
    end
    if (!rst_n || hold_left != 0) begin
      rx_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_ready <= 1'b0;
      rx_gap--;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_go)
      hold_left <= LONG_HOLD;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[priority_task_scheduler_top] ERROR");
      $finish;
    end
  end

  task automatic send_request(input func_t fn, input logic [DLY_W-1:0] dly,
                              input logic [MASK_W-1:0] evp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_func  <= fn;
    req_dly   <= dly;
    req_evp   <= evp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_step(fn, dly, evp);
  endtask

  task automatic send_random_request();
    func_t fn;
    logic [DLY_W-1:0] dly;
    logic [MASK_W-1:0] evp;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      fn = FN_TICK;
    else if (r < 65) fn = FN_DELAY;
    else if (r < 85) fn = FN_WAIT;
    else             fn = FN_START;
    r = $urandom_range(0, 19);
    if (r == 0)     dly = '0;
    else if (r < 3) dly = DLY_W'($urandom_range(0, 65535));
    else            dly = DLY_W'($urandom_range(1, 12));
    r = $urandom_range(0, 9);
    if (r == 0)      evp = '0;
    else if (r == 1) evp = '1;
    else             evp = MASK_W'($urandom_range(0, 255));
    send_request(fn, dly, evp);
  endtask

  // let every outstanding word come back, then let the block settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sched_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    model_config(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [MASK_W-1:0] present,
                             input logic [MASK_W-1:0] evt_en,
                             input logic [INTERVAL_W-1:0] interval);
    wait_idle();
    write_reg(CFG_TASK_PRESENT, CFG_DATA_W'(present));
    write_reg(CFG_EVENT_ENABLED, CFG_DATA_W'(evt_en));
    write_reg(CFG_SWITCH_INTERVAL, CFG_DATA_W'(interval));
  endtask

  function automatic logic [DLY_W-1:0] junk_dly();
    return DLY_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [MASK_W-1:0] junk_evp();
    return MASK_W'($urandom_range(0, 255));
  endfunction

  // nothing created yet: every request falls through
  task automatic test_empty_table();
    send_request(FN_START, junk_dly(), junk_evp());
    send_request(FN_TICK, junk_dly(), junk_evp());
    send_request(FN_DELAY, 16'd5, junk_evp());
    send_request(FN_WAIT, junk_dly(), 8'h00);
  endtask

  task automatic test_delays_and_events();
    reconfigure(8'hFF, 8'h00, 10'd10);
    send_request(FN_START, junk_dly(), junk_evp());
    send_request(FN_DELAY, 16'd0, junk_evp());     // zero delay: no change
    send_request(FN_DELAY, 16'd1, junk_evp());
    send_request(FN_DELAY, 16'hFFFF, junk_evp());
    send_request(FN_DELAY, 16'd3, junk_evp());
    send_request(FN_WAIT, junk_dly(), 8'h00);       // no event word: ignored
    send_request(FN_TICK, junk_dly(), 8'h00);
    send_request(FN_TICK, junk_dly(), 8'h00);       // first delay expires
    reconfigure(8'hFF, 8'h81, 10'd1);
    send_request(FN_WAIT, junk_dly(), 8'h01);       // own event bit set
    send_request(FN_WAIT, junk_dly(), 8'hFE);
    send_request(FN_TICK, junk_dly(), 8'h80);
    send_request(FN_TICK, junk_dly(), 8'h01);
    send_request(FN_DELAY, 16'd5, junk_evp());
    send_request(FN_TICK, junk_dly(), 8'hFF);       // event wins over delay
    send_request(FN_DELAY, 16'd7, junk_evp());      // delay still active
  endtask

  task automatic test_table_changes();
    reconfigure(8'hFE, 8'h81, 10'd0);               // drops the running task
    send_request(FN_DELAY, 16'd2, junk_evp());
    send_request(FN_START, junk_dly(), junk_evp());
    send_request(FN_TICK, junk_dly(), 8'h00);
    reconfigure(8'h01, 8'h01, 10'd1023);
    send_request(FN_START, junk_dly(), junk_evp());
    send_request(FN_TICK, junk_dly(), 8'h00);
    send_request(FN_START, junk_dly(), junk_evp()); // nothing runnable
    send_request(FN_DELAY, 16'd4, junk_evp());
  endtask

  task automatic test_random_traffic();
    logic [INTERVAL_W-1:0] interval;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0:       interval = 10'd1;
        1:       interval = 10'd1023;
        2:       interval = INTERVAL_W'($urandom_range(1, 20));
        default: interval = INTERVAL_W'($urandom_range(1, 1023));
      endcase
      reconfigure(MASK_W'($urandom_range(0, 255)),
                  MASK_W'($urandom & $urandom), interval);
      tx_idle = (ph % 3 != 2);
      rx_idle = (ph % 3 != 1);
      repeat (115) send_random_request();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver stalls while requests keep coming until the input backs up
  task automatic test_backpressure();
    reconfigure(8'hFF, 8'h0F, 10'd3);
    tx_idle = 1'b0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (40) send_random_request();
    tx_idle = 1'b1;
  endtask

  initial begin
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_delays_and_events();
    test_table_changes();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("[priority_task_scheduler_top] OK");
    end else begin
      $display("[priority_task_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule
